@@ rtl/roc_pkg.sv @@
// Shared constants and controller/datapath interface types for the overlap counter.
package roc_pkg;

    localparam int GRID_WIDTH  = 1024;
    localparam int GRID_HEIGHT = 1024;

    localparam longint CELLS  = longint'(GRID_WIDTH) * longint'(GRID_HEIGHT);
    localparam int     ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int     COL_W  = $clog2(GRID_WIDTH + 1);

    localparam int LEFT_W  = 10;
    localparam int TOP_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int TOTAL_W = 21;
    // room for left+width and top+height against grid sizes below 2^18
    localparam int SUM_W   = 18;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic [1:0] CELL_ONCE = 2'd1;
    localparam logic [1:0] CELL_SAT  = 2'd2;

    typedef struct packed {
        logic clr;       // clearing pass: zero one cell
        logic load;      // capture a new rectangle
        logic step;      // issue a read for the next cell of the walk
        logic out_load;  // capture the result into the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;  // clearing pass is at its final cell
        logic skip;      // rectangle rejected or empty
        logic last;      // walk is at its final cell
    } t_sts;

endpackage

@@ rtl/roc_ctrl.sv @@
// Controller state machine: clearing pass, rectangle walk sequencing and result handoff.
module roc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  roc_pkg::t_sts i_sts,
    output roc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_sts.skip ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) n_state = ST_DRAIN;
            end
            // last read-modify-write lands here
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/roc_dpath.sv @@
// Datapath: coverage memory, cell walk counters, overlap total and result register.
module roc_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  roc_pkg::t_cmd                 i_cmd,
    output roc_pkg::t_sts                 o_sts,
    input  logic [roc_pkg::LEFT_W-1:0]    i_left,
    input  logic [roc_pkg::TOP_W-1:0]     i_top,
    input  logic [roc_pkg::SIZE_W-1:0]    i_width,
    input  logic [roc_pkg::SIZE_W-1:0]    i_height,
    output logic [roc_pkg::TOTAL_W-1:0]   o_overlap_cells,
    output logic                          o_rejected
);

    logic [1:0] r_mem [0:roc_pkg::CELLS-1];

    logic [roc_pkg::ADDR_W-1:0]  r_clr_addr;
    logic [roc_pkg::COL_W-1:0]   r_left, r_col, r_col_end;
    logic [roc_pkg::SIZE_W-1:0]  r_rows;
    logic [roc_pkg::ADDR_W-1:0]  r_row_base;
    logic                        r_reject, r_empty;
    logic [roc_pkg::ADDR_W-1:0]  rd_addr, r_rd_addr;
    logic                        r_rd_vld;
    logic [1:0]                  r_rd_data;
    logic [roc_pkg::TOTAL_W-1:0] r_total;
    logic [roc_pkg::TOTAL_W-1:0] r_out_total;
    logic                        r_out_rej;
    logic [roc_pkg::SUM_W-1:0]   h_end, v_end;
    logic [roc_pkg::COL_W-1:0]   col_next;
    logic                        row_end;

    assign h_end = roc_pkg::SUM_W'(i_left) + roc_pkg::SUM_W'(i_width);
    assign v_end = roc_pkg::SUM_W'(i_top) + roc_pkg::SUM_W'(i_height);

    assign col_next = r_col + roc_pkg::COL_W'(1);
    assign row_end  = (col_next == r_col_end);
    assign rd_addr  = r_row_base + roc_pkg::ADDR_W'(r_col);

    assign o_sts.clr_last = (r_clr_addr == roc_pkg::ADDR_W'(roc_pkg::CELLS - 1));
    assign o_sts.skip     = r_reject || r_empty;
    assign o_sts.last     = row_end && (r_rows == roc_pkg::SIZE_W'(1));

    // rectangle capture and walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_reject   <= (h_end > roc_pkg::SUM_W'(roc_pkg::GRID_WIDTH)) ||
                          (v_end > roc_pkg::SUM_W'(roc_pkg::GRID_HEIGHT));
            r_empty    <= (i_width == '0) || (i_height == '0);
            r_left     <= roc_pkg::COL_W'(i_left);
            r_col      <= roc_pkg::COL_W'(i_left);
            r_col_end  <= roc_pkg::COL_W'(h_end);
            r_rows     <= i_height;
            r_row_base <= roc_pkg::ADDR_W'(longint'(i_top) * longint'(roc_pkg::GRID_WIDTH));
        end else if (i_cmd.step) begin
            if (row_end) begin
                r_col      <= r_left;
                r_rows     <= r_rows - roc_pkg::SIZE_W'(1);
                r_row_base <= r_row_base + roc_pkg::ADDR_W'(roc_pkg::GRID_WIDTH);
            end else begin
                r_col <= col_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + roc_pkg::ADDR_W'(1);
        end
    end

    // read stage; write-back in the next cycle, addresses differ within a walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        if (i_cmd.step) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_rd_vld && (r_rd_data != roc_pkg::CELL_SAT)) begin
            r_mem[r_rd_addr] <= r_rd_data + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (r_rd_vld && (r_rd_data == roc_pkg::CELL_ONCE)) begin
            r_total <= r_total + roc_pkg::TOTAL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_total <= r_total;
            r_out_rej   <= r_reject;
        end
    end

    assign o_overlap_cells = r_out_total;
    assign o_rejected      = r_out_rej;

endmodule

@@ rtl/rectangle_overlap_counter_core.sv @@
// Top level of the rectangle overlap counter: stream ports, controller and datapath.
//
// Each input beat on the s_axis channel is one rectangle (left, top, width,
// height). The block marks its cells in a 1024 x 1024 grid of 2-bit cover
// counts and returns one beat on m_axis with the running number of cells
// covered twice or more, plus a reject flag in tuser when the rectangle
// runs past the grid edge (such a rectangle draws nothing).
// One rectangle is in work at a time. The cell walk does one read-modify-
// write per cycle on the coverage memory. After a check state, a drawn
// rectangle walks its cells and then drains the last write; an empty or
// rejected one skips both. The next rectangle is accepted as soon as the
// result is placed in the output register, even if the receiver has not
// taken it yet. If the receiver stalls, the result holds and the block
// finishes at most one more rectangle before it waits for the output
// register to free.
// After reset the block runs a clearing pass over the coverage memory,
// one cell per cycle, with s_axis_tready low throughout.
module rectangle_overlap_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // left[9:0], top[19:10], width[30:20], height[41:31]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // overlap_cells[20:0]
    output logic        m_axis_tuser    // rejected
);

    roc_pkg::t_cmd                 cmd;
    roc_pkg::t_sts                 sts;
    logic [roc_pkg::TOTAL_W-1:0]   overlap_cells;

    roc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    roc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_left          (s_axis_tdata[9:0]),
        .i_top           (s_axis_tdata[19:10]),
        .i_width         (s_axis_tdata[30:20]),
        .i_height        (s_axis_tdata[41:31]),
        .o_overlap_cells (overlap_cells),
        .o_rejected      (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, overlap_cells};

endmodule

@@ rtl/roc_chk.sv @@
// Port-level checker for the overlap counter, bound to the top level.
module roc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [20:0] r_prev_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_total <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_prev_total <= m_axis_tdata[20:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second rectangle taken while one is in work");

    a_reject_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[20:0] == r_prev_total)
        else $error("rejected rectangle changed the overlap total");

endmodule

bind rectangle_overlap_counter_core roc_chk u_roc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
